FILE: design/eamq_pkg.sv
// Shared types and constants for the entity allocator with mask query.
// No dependencies; imported by entity_allocator_mask_query.
`default_nettype none

package eamq_pkg;

  // Default sizes for the top-level parameters
  localparam int unsigned MAX_ENTITIES_DEF   = 64;
  localparam int unsigned MAX_COMPONENTS_DEF = 32;

  // Fixed field widths
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ENTITY_W = 6;
  localparam int unsigned COMP_W   = 5;
  localparam int unsigned QMASK_W  = 32;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_CREATE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DESTROY   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADD_COMP  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY_ALL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY_ANY = 3'd4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD      = 2'd3
  } status_e;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ENTITY_W-1:0] entity;
    logic [COMP_W-1:0]   component;
    logic [QMASK_W-1:0]  query_mask;
  } in_word_t;

  typedef struct packed {
    logic [ENTITY_W-1:0] entity_id;
    status_e             status;
    logic                last;
  } out_word_t;

endpackage

`default_nettype wire

FILE: design/entity_allocator_mask_query.sv
// Entity allocator: mask table, LIFO free-ID stack and query scanner.
// Depends on eamq_pkg.
`default_nettype none

// One input word is processed at a time. Destroy, create at the high-water
// mark, table full and a bad entity go straight to the response state. Create
// from the free stack and add-component first pass through a state for the
// memory read. A query streams the mask table through its single read port,
// one entity per cycle unless the output side stalls. Matching IDs come out
// in ascending order with last set on the final word; an empty query gives
// one no-match word. Results wait in an output register, so the next word is
// accepted while a result is still unread.
module entity_allocator_mask_query
  import eamq_pkg::*;
#(
  parameter int unsigned MAX_ENTITIES   = MAX_ENTITIES_DEF,
  parameter int unsigned MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output out_word_t  out_word_o
);

  localparam int unsigned IW = $clog2(MAX_ENTITIES);      // table index
  localparam int unsigned CW = $clog2(MAX_ENTITIES + 1);  // counts up to capacity
  localparam int unsigned MW = (MAX_COMPONENTS >= QMASK_W) ? QMASK_W : MAX_COMPONENTS;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_POP  = 5'b00010,
    S_ADD  = 5'b00100,
    S_SCAN = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  logic [CW-1:0]           fc_q, fc_d;
  logic [CW-1:0]           hw_q, hw_d;
  logic [MAX_ENTITIES-1:0] live_q, live_d;
  logic [CW-1:0]           scan_q, scan_d;
  logic                    rd_valid_q, rd_valid_d;
  logic [IW-1:0]           rd_id_q, rd_id_d;
  logic                    pend_valid_q, pend_valid_d;
  logic [IW-1:0]           pend_id_q, pend_id_d;
  logic                    out_valid_q;

  out_word_t               resp_q, resp_d;
  out_word_t               out_q, out_d;
  logic [MW-1:0]           qm_q, qm_d;
  logic                    any_q, any_d;
  logic [IW-1:0]           ent_q, ent_d;
  logic [COMP_W-1:0]       comp_q, comp_d;

  // Memories
  logic [MW-1:0]           mask_mem [MAX_ENTITIES];
  logic [IW-1:0]           fs_mem   [MAX_ENTITIES];
  logic [MW-1:0]           mask_rdata_q;
  logic [IW-1:0]           fs_rdata_q;

  logic                    mask_we, mask_re;
  logic [IW-1:0]           mask_waddr, mask_raddr;
  logic [MW-1:0]           mask_wdata;
  logic                    fs_we, fs_re;
  logic [IW-1:0]           fs_waddr, fs_raddr;
  logic [IW-1:0]           fs_wdata;

  logic                    in_acc, out_free, out_load;
  logic                    ent_ok, issue, hit, stall, scan_done;
  logic [MW-1:0]           masked;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Live means below the high-water mark and marked live
  assign ent_ok = (7'(in_word_i.entity) < 7'(hw_q)) && live_q[in_word_i.entity[IW-1:0]];

  assign issue     = scan_q < hw_q;
  assign scan_done = !issue && !rd_valid_q;
  assign masked    = mask_rdata_q & qm_q;
  assign hit       = rd_valid_q && live_q[rd_id_q] &&
                     (any_q ? (|masked) : (masked == qm_q));
  // a second hit waits until the output register is free to take the held one
  assign stall     = hit && pend_valid_q && !out_free;

  always_comb begin
    state_d      = state_q;
    fc_d         = fc_q;
    hw_d         = hw_q;
    live_d       = live_q;
    scan_d       = scan_q;
    rd_valid_d   = rd_valid_q;
    rd_id_d      = rd_id_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    resp_d       = resp_q;
    out_d        = out_q;
    out_load     = 1'b0;
    qm_d         = qm_q;
    any_d        = any_q;
    ent_d        = ent_q;
    comp_d       = comp_q;
    mask_we      = 1'b0;
    mask_waddr   = '0;
    mask_wdata   = '0;
    mask_re      = 1'b0;
    mask_raddr   = '0;
    fs_we        = 1'b0;
    fs_waddr     = '0;
    fs_wdata     = '0;
    fs_re        = 1'b0;
    fs_raddr     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_word_i.kind)
            KIND_CREATE: begin
              if (fc_q != '0) begin
                fs_re    = 1'b1;
                fs_raddr = IW'(fc_q - CW'(1));
                fc_d     = fc_q - CW'(1);
                state_d  = S_POP;
              end else if (hw_q < CW'(MAX_ENTITIES)) begin
                mask_we                = 1'b1;
                mask_waddr             = hw_q[IW-1:0];
                live_d[hw_q[IW-1:0]]   = 1'b1;
                hw_d                   = hw_q + CW'(1);
                resp_d = '{entity_id: ENTITY_W'(hw_q), status: ST_OK, last: 1'b1};
                state_d                = S_RESP;
              end else begin
                resp_d  = '{entity_id: '0, status: ST_FULL, last: 1'b1};
                state_d = S_RESP;
              end
            end
            KIND_DESTROY: begin
              if (ent_ok) begin
                fs_we    = 1'b1;
                fs_waddr = fc_q[IW-1:0];
                fs_wdata = in_word_i.entity[IW-1:0];
                fc_d     = fc_q + CW'(1);
                live_d[in_word_i.entity[IW-1:0]] = 1'b0;
                resp_d = '{entity_id: in_word_i.entity, status: ST_OK, last: 1'b1};
              end else begin
                resp_d = '{entity_id: in_word_i.entity, status: ST_BAD, last: 1'b1};
              end
              state_d = S_RESP;
            end
            KIND_ADD_COMP: begin
              if (ent_ok) begin
                mask_re    = 1'b1;
                mask_raddr = in_word_i.entity[IW-1:0];
                ent_d      = in_word_i.entity[IW-1:0];
                comp_d     = in_word_i.component;
                state_d    = S_ADD;
              end else begin
                resp_d  = '{entity_id: in_word_i.entity, status: ST_BAD, last: 1'b1};
                state_d = S_RESP;
              end
            end
            KIND_QUERY_ALL, KIND_QUERY_ANY: begin
              qm_d         = in_word_i.query_mask[MW-1:0];
              any_d        = (in_word_i.kind == KIND_QUERY_ANY);
              scan_d       = '0;
              rd_valid_d   = 1'b0;
              pend_valid_d = 1'b0;
              state_d      = S_SCAN;
            end
            default: ;  // unused kinds are dropped
          endcase
        end
      end

      S_POP: begin
        mask_we            = 1'b1;
        mask_waddr         = fs_rdata_q;
        live_d[fs_rdata_q] = 1'b1;
        resp_d  = '{entity_id: ENTITY_W'(fs_rdata_q), status: ST_OK, last: 1'b1};
        state_d = S_RESP;
      end

      S_ADD: begin
        // bit index past the mask width shifts out to no change
        mask_we    = 1'b1;
        mask_waddr = ent_q;
        mask_wdata = mask_rdata_q | (MW'(1) << comp_q);
        resp_d     = '{entity_id: ENTITY_W'(ent_q), status: ST_OK, last: 1'b1};
        state_d    = S_RESP;
      end

      S_SCAN: begin
        if (scan_done) begin
          if (pend_valid_q) begin
            resp_d = '{entity_id: ENTITY_W'(pend_id_q), status: ST_OK, last: 1'b1};
          end else begin
            resp_d = '{entity_id: '0, status: ST_NO_MATCH, last: 1'b1};
          end
          state_d = S_RESP;
        end else if (!stall) begin
          // hold back each hit until the next one shows it is not last
          if (hit) begin
            if (pend_valid_q) begin
              out_load = 1'b1;
              out_d = '{entity_id: ENTITY_W'(pend_id_q), status: ST_OK, last: 1'b0};
            end
            pend_valid_d = 1'b1;
            pend_id_d    = rd_id_q;
          end
          mask_re    = issue;
          mask_raddr = scan_q[IW-1:0];
          rd_valid_d = issue;
          rd_id_d    = scan_q[IW-1:0];
          if (issue) begin
            scan_d = scan_q + CW'(1);
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = resp_q;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fc_q         <= '0;
      hw_q         <= '0;
      live_q       <= '0;
      scan_q       <= '0;
      rd_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fc_q         <= fc_d;
      hw_q         <= hw_d;
      live_q       <= live_d;
      scan_q       <= scan_d;
      rd_valid_q   <= rd_valid_d;
      pend_valid_q <= pend_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_id_q   <= rd_id_d;
    pend_id_q <= pend_id_d;
    resp_q    <= resp_d;
    out_q     <= out_d;
    qm_q      <= qm_d;
    any_q     <= any_d;
    ent_q     <= ent_d;
    comp_q    <= comp_d;
  end

  // Mask table
  always_ff @(posedge clk_i) begin
    if (mask_we) begin
      mask_mem[mask_waddr] <= mask_wdata;
    end
    if (mask_re) begin
      mask_rdata_q <= mask_mem[mask_raddr];
    end
  end

  // Free-ID stack
  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    if (fs_re) begin
      fs_rdata_q <= fs_mem[fs_raddr];
    end
  end

endmodule

`default_nettype wire
